// ===== hw/rtl/ltmd_pkg.sv =====
// ----------------------------------------------------------------------------
// ltmd_pkg
// shared types and constants of the loser tree merge with hash dedup
// ----------------------------------------------------------------------------
package ltmd_pkg;

   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [4:0]  WAYS_RESET = 5'd16;

   typedef struct packed {
      logic [63:0] hash;
      logic [31:0] counter;
      logic [63:0] nonce;
   } rec_type;

   typedef struct packed {
      logic [63:0] key_hash;
      logic [31:0] rec_counter;
      logic [63:0] rec_nonce;
      logic        exhausted;
   } req_type;

   typedef struct packed {
      logic        emit_valid;
      logic [63:0] out_hash;
      logic        is_duplicate;
      logic        is_collision;
      logic [3:0]  next_source;
      logic        done_res;
   } rsp_type;

endpackage

// ===== hw/rtl/loser_tree_merge_dedup.sv =====
// ----------------------------------------------------------------------------
// loser_tree_merge_dedup
// k-way merge of sorted record streams into distinct hashes, one tree level
// per cycle through a shared 64-bit compare against the node memory
//
// each word replays L = floor(log2(ways + source)) tree levels in S_CLIMB,
// one level a cycle through the node memory port, then S_DONE forms the
// result; after the merge has finished a word is answered from S_IDLE
// reset: synchronous; nodes read as zero records with their own index as
// source through per-node valid bits, ways_ff returns to 16
// ----------------------------------------------------------------------------
module loser_tree_merge_dedup #(
   parameter int MAX_WAYS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ltmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ltmd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [4:0]        csr_wdata
);

   localparam int LIVE = (MAX_WAYS < 31) ? MAX_WAYS : 31;
   localparam int IW   = (LIVE > 1) ? $clog2(LIVE) : 1;
   localparam int PW   = $clog2(LIVE + 1);
   localparam int SW   = PW + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CLIMB = 2'd1;
   localparam logic [1:0] S_DONE  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [4:0]        ways_ff;
   logic [PW-1:0]     ph_ff, ph_in;
   logic              finished_ff, finished_in;
   logic [IW-1:0]     wanted_ff, wanted_in;
   ltmd_pkg::rec_type winner_ff, winner_in;
   ltmd_pkg::rec_type prev_ff, prev_in;
   ltmd_pkg::rec_type q_ff, q_in;
   logic [IW-1:0]     qsrc_ff, qsrc_in;
   logic [IW-1:0]     t_ff, t_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ltmd_pkg::rsp_type rsp_ff, rsp_in;
   logic [LIVE-1:0]   vld_ff, vld_in;

   ltmd_pkg::rec_type node_rec_mem [LIVE];
   logic [IW-1:0]     node_src_mem [LIVE];
   ltmd_pkg::rec_type rd_rec_ff;
   logic [IW-1:0]     rd_src_ff;
   logic [IW-1:0]     rd_idx_ff;
   logic              rd_vld_ff;
   logic [IW-1:0]     rd_addr;
   logic              wr_en;

   logic [PW-1:0]     p_eff;
   logic [PW-1:0]     p_new;
   logic [IW-1:0]     src_start;
   logic [SW-1:0]     t_sum;
   logic [IW-1:0]     t_start;
   logic [IW-1:0]     t_half;
   ltmd_pkg::rec_type rec_in;
   ltmd_pkg::rec_type node_rec;
   logic [IW-1:0]     node_src;
   logic              swap;
   logic              req_take;
   logic              rsp_take;

   function automatic logic [PW-1:0] eff_ways(input logic [4:0] w);
      logic [PW-1:0] r;
      if (w == 5'd0) begin
         r = PW'(1);
      end else if (32'(w) > 32'(LIVE)) begin
         r = PW'(LIVE);
      end else begin
         r = PW'(w);
      end
      return r;
   endfunction

   assign p_eff     = eff_ways(ways_ff);
   assign p_new     = eff_ways(csr_wdata);
   assign src_start = (32'(wanted_ff) >= 32'(p_eff)) ? '0 : wanted_ff;
   assign t_sum     = SW'(p_eff) + SW'(src_start);
   assign t_start   = t_sum[IW:1];
   assign t_half    = t_ff >> 1;

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign node_rec = rd_vld_ff ? rd_rec_ff : '0;
   assign node_src = rd_vld_ff ? rd_src_ff : rd_idx_ff;
   assign swap     = node_rec.hash < q_ff.hash;
   assign wr_en    = (state_ff == S_CLIMB) && swap;
   assign rd_addr  = (state_ff == S_IDLE) ? t_start : t_half;

   always_comb begin
      if (req_data.exhausted) begin
         rec_in = '{hash: ltmd_pkg::ALL_ONES, counter: 32'd0, nonce: 64'd0};
      end else begin
         rec_in = '{hash: req_data.key_hash, counter: req_data.rec_counter,
                    nonce: req_data.rec_nonce};
      end
   end

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      finished_in  = finished_ff;
      wanted_in    = wanted_ff;
      winner_in    = winner_ff;
      prev_in      = prev_ff;
      q_in         = q_ff;
      qsrc_in      = qsrc_ff;
      t_in         = t_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (finished_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{emit_valid: 1'b0, out_hash: ltmd_pkg::ALL_ONES,
                             is_duplicate: 1'b0, is_collision: 1'b0,
                             next_source: 4'(wanted_ff), done_res: 1'b1};
               end else begin
                  ph_in   = (ph_ff == '0) ? '0 : ph_ff - PW'(1);
                  prev_in = winner_ff;
                  q_in    = rec_in;
                  qsrc_in = src_start;
                  t_in    = t_start;
                  state_in = (t_start == '0) ? S_DONE : S_CLIMB;
               end
            end
         end
         S_CLIMB: begin
            if (swap) begin
               q_in    = node_rec;
               qsrc_in = node_src;
               vld_in[t_ff] = 1'b1;
            end
            t_in     = t_half;
            state_in = (t_half == '0) ? S_DONE : S_CLIMB;
         end
         S_DONE: begin
            winner_in    = q_ff;
            wanted_in    = qsrc_ff;
            rsp_valid_in = 1'b1;
            rsp_in.emit_valid   = 1'b0;
            rsp_in.is_duplicate = 1'b0;
            rsp_in.is_collision = 1'b0;
            rsp_in.next_source  = 4'(qsrc_ff);
            rsp_in.out_hash     = q_ff.hash;
            rsp_in.done_res     = 1'b0;
            if (q_ff.hash == ltmd_pkg::ALL_ONES) begin
               finished_in     = 1'b1;
               rsp_in.done_res = 1'b1;
            end else if (ph_ff == '0) begin
               if (q_ff.hash != prev_ff.hash) begin
                  rsp_in.emit_valid = 1'b1;
               end else if (q_ff.counter == prev_ff.counter &&
                            q_ff.nonce == prev_ff.nonce) begin
                  rsp_in.is_duplicate = 1'b1;
               end else begin
                  rsp_in.is_collision = 1'b1;
               end
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ways_ff      <= ltmd_pkg::WAYS_RESET;
         ph_ff        <= eff_ways(ltmd_pkg::WAYS_RESET);
         finished_ff  <= 1'b0;
         wanted_ff    <= '0;
         winner_ff    <= '0;
         prev_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (csr_we) begin
         state_ff     <= S_IDLE;
         ways_ff      <= csr_wdata;
         ph_ff        <= p_new;
         finished_ff  <= 1'b0;
         wanted_ff    <= '0;
         winner_ff    <= '0;
         prev_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= rsp_valid_in;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         finished_ff  <= finished_in;
         wanted_ff    <= wanted_in;
         winner_ff    <= winner_in;
         prev_ff      <= prev_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      qsrc_ff <= qsrc_in;
      t_ff    <= t_in;
      rsp_ff  <= rsp_in;
   end

   // node memory, at most one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_rec_mem[t_ff] <= q_ff;
         node_src_mem[t_ff] <= qsrc_ff;
      end
      rd_rec_ff <= node_rec_mem[rd_addr];
      rd_src_ff <= node_src_mem[rd_addr];
      rd_idx_ff <= rd_addr;
      rd_vld_ff <= vld_ff[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("input taken while tree replay in progress");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.emit_valid, rsp_ff.is_duplicate,
                                 rsp_ff.is_collision, rsp_ff.done_res}))
      else $error("conflicting result flags");

   a_climb_node: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLIMB |-> t_ff != '0)
      else $error("tree replay at node zero");

   a_finished_winner: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> winner_ff.hash == ltmd_pkg::ALL_ONES)
      else $error("merge finished without all-ones winner");

endmodule

// ===== verif/tb_loser_tree_merge_dedup.sv =====
// ----------------------------------------------------------------------------
// tb_loser_tree_merge_dedup
// self-checking testbench of the loser tree merge with hash dedup: sorted
// record streams are fed in the order the block requests them, a predictor
// tracks the tree and the dedup state, and every result word is compared
// field by field under random idling, stalls and stream counts
// ----------------------------------------------------------------------------
module tb_loser_tree_merge_dedup;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WAYS_MAX     = 16;
   localparam int ITEM_GOAL    = 1950;
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int SHOW_LIMIT   = 10;

   class merge_ledger;
      ltmd_pkg::rec_type tree_rec[WAYS_MAX];
      logic [3:0]        tree_src[WAYS_MAX];
      ltmd_pkg::rec_type champion;
      ltmd_pkg::rec_type prior;
      logic [3:0]        want_src;
      int unsigned       fills_left;
      bit                merge_over;
      logic [4:0]        ways_reg;
      ltmd_pkg::rsp_type expected_words[$];
      int                mismatches;

      function int unsigned lanes();
         if (ways_reg == 5'd0) return 1;
         if (ways_reg > WAYS_MAX) return WAYS_MAX;
         return 32'(ways_reg);
      endfunction

      function void restart(logic [4:0] ways);
         int t;
         ways_reg = ways;
         for (t = 0; t < WAYS_MAX; t++) begin
            tree_rec[t] = '0;
            tree_src[t] = 4'(t);
         end
         champion   = '0;
         prior      = '0;
         want_src   = '0;
         fills_left = lanes();
         merge_over = 1'b0;
      endfunction

      function void note_record(ltmd_pkg::req_type w);
         ltmd_pkg::rec_type q;
         ltmd_pkg::rec_type r;
         logic [3:0]        s;
         int unsigned       p;
         int unsigned       t;
         int unsigned       src;
         ltmd_pkg::rsp_type o;
         o = '0;
         p = lanes();
         if (!merge_over) begin
            if (fills_left > 0) fills_left--;
            prior = champion;
            if (w.exhausted) begin
               q.hash    = ltmd_pkg::ALL_ONES;
               q.counter = '0;
               q.nonce   = '0;
            end else begin
               q.hash    = w.key_hash;
               q.counter = w.rec_counter;
               q.nonce   = w.rec_nonce;
            end
            src = want_src;
            if (src >= p) src = 0;
            t = (p + src) / 2;
            // replay from the leaf toward the root, losers stay in the nodes
            while (t >= 1 && t < WAYS_MAX) begin
               if (tree_rec[t].hash < q.hash) begin
                  r = tree_rec[t];
                  s = tree_src[t];
                  tree_rec[t] = q;
                  tree_src[t] = 4'(src);
                  q   = r;
                  src = s;
               end
               t = t / 2;
            end
            champion = q;
            want_src = 4'(src);
            if (q.hash == ltmd_pkg::ALL_ONES) begin
               merge_over = 1'b1;
            end else if (fills_left == 0) begin
               if (q.hash != prior.hash) o.emit_valid = 1'b1;
               else if (q.counter == prior.counter && q.nonce == prior.nonce)
                  o.is_duplicate = 1'b1;
               else o.is_collision = 1'b1;
            end
         end
         o.out_hash    = merge_over ? ltmd_pkg::ALL_ONES : champion.hash;
         o.next_source = want_src;
         o.done_res    = merge_over;
         expected_words.push_back(o);
      endfunction

      function void check_word(ltmd_pkg::rsp_type a);
         ltmd_pkg::rsp_type e;
         if (expected_words.size() == 0) begin
            if (mismatches < SHOW_LIMIT) $display("word with nothing expected: %h", a);
            mismatches++;
         end else begin
            e = expected_words.pop_front();
            if (a.emit_valid !== e.emit_valid || a.out_hash !== e.out_hash ||
                a.is_duplicate !== e.is_duplicate || a.is_collision !== e.is_collision ||
                a.next_source !== e.next_source || a.done_res !== e.done_res) begin
               if (mismatches < SHOW_LIMIT) begin
                  $display("mismatch expected emit %b hash %h dup %b col %b src %0d done %b",
                           e.emit_valid, e.out_hash, e.is_duplicate, e.is_collision,
                           e.next_source, e.done_res);
                  $display("         actual   emit %b hash %h dup %b col %b src %0d done %b",
                           a.emit_valid, a.out_hash, a.is_duplicate, a.is_collision,
                           a.next_source, a.done_res);
               end
               mismatches++;
            end
         end
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   ltmd_pkg::req_type req_data  = '0;
   logic              rsp_stall = 1'b0;
   logic              csr_we    = 1'b0;
   logic [4:0]        csr_wdata = '0;
   logic              req_stall;
   logic              rsp_valid;
   ltmd_pkg::rsp_type rsp_data;

   merge_ledger       ledger = new();
   ltmd_pkg::rec_type streams[WAYS_MAX][$];
   ltmd_pkg::rec_type pool[4];
   int                idle_pct  = 0;
   int                stall_pct = 0;
   int                hold_asks = 0;
   int                hold_seen = 0;
   int                hold_left = 0;
   int                quiet     = 0;
   int                sent      = 0;

   loser_tree_merge_dedup dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ledger.check_word(rsp_data);
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic ltmd_pkg::req_type random_word();
      ltmd_pkg::req_type w;
      w.key_hash    = {$urandom, $urandom};
      w.rec_counter = $urandom;
      w.rec_nonce   = {$urandom, $urandom};
      w.exhausted   = 1'($urandom_range(1));
      return w;
   endfunction

   function automatic ltmd_pkg::rec_type rec_of(logic [63:0] h, logic [31:0] c,
                                                logic [63:0] n);
      ltmd_pkg::rec_type r;
      r.hash    = h;
      r.counter = c;
      r.nonce   = n;
      return r;
   endfunction

   // entered and left at a rising edge with nothing driven yet in that step
   task automatic send_word(ltmd_pkg::req_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!(req_valid && !req_stall));
      ledger.note_record(w);
      sent++;
   endtask

   task automatic build_streams(int p, int len_max);
      ltmd_pkg::rec_type r;
      int                i;
      int                s;
      int                n;
      int                k;
      for (i = 0; i < 4; i++) pool[i] = rec_of({$urandom, $urandom}, $urandom_range(1),
                                               64'($urandom_range(1)));
      if ($urandom_range(3) == 0) pool[0].hash = '0;
      for (s = 0; s < WAYS_MAX; s++) begin
         streams[s].delete();
         if (s < p) begin
            n = $urandom_range(len_max);
            repeat (n) begin
               if ($urandom_range(9) < 4) begin
                  r = pool[$urandom_range(3)];
                  if ($urandom_range(1) == 0) r.counter = $urandom;
               end else begin
                  r = rec_of({$urandom, $urandom}, $urandom, {$urandom, $urandom});
               end
               k = 0;
               while (k < streams[s].size() && streams[s][k].hash <= r.hash) k++;
               streams[s].insert(k, r);
            end
         end
      end
   endtask

   task automatic feed_streams(int pause_at);
      ltmd_pkg::req_type w;
      ltmd_pkg::rec_type r;
      logic [3:0]        s;
      int                k;
      int                extra;
      k = 0;
      while (!ledger.merge_over) begin
         if (k == pause_at) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (ledger.expected_words.size() != 0);
         end
         s = ledger.want_src;
         w = random_word();
         if (streams[s].size() == 0) begin
            w.exhausted = 1'b1;
         end else begin
            r = streams[s].pop_front();
            w.key_hash    = r.hash;
            w.rec_counter = r.counter;
            w.rec_nonce   = r.nonce;
            w.exhausted   = 1'b0;
         end
         send_word(w);
         k++;
      end
      // words after the merge has ended
      extra = $urandom_range(1, 2);
      repeat (extra) send_word(random_word());
   endtask

   task automatic feed_noise(int n);
      ltmd_pkg::req_type w;
      repeat (n) begin
         w = random_word();
         case ($urandom_range(7))
            0: w.key_hash = '0;
            1: w.key_hash = ltmd_pkg::ALL_ONES;
            2: w.key_hash = pool[$urandom_range(3)].hash;
            default: ;
         endcase
         w.exhausted = ($urandom_range(7) == 0);
         send_word(w);
      end
   endtask

   task automatic end_phase(logic [4:0] ways);
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.expected_words.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= ways;
      @(posedge clock);
      ledger.restart(ways);
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 56; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 56; end
         default: begin idle_pct = 19; stall_pct = 19; end
      endcase
   endtask

   initial begin
      int         phase;
      int         p;
      int         pick;
      logic [4:0] ways;
      ledger.restart(ltmd_pkg::WAYS_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset stream count
      set_idling(0);
      build_streams(WAYS_MAX, 2);
      feed_streams(-1);

      // two streams: zero hashes, duplicate, collision, extreme values,
      // a real all-ones hash ending a stream
      end_phase(5'd2);
      set_idling(3);
      build_streams(0, 0);
      streams[0].push_back(rec_of('0, '0, '0));
      streams[0].push_back(rec_of(64'd5, 32'd1, 64'd1));
      streams[0].push_back(rec_of(64'd5, 32'd1, 64'd1));
      streams[0].push_back(rec_of(64'd9, '1, '1));
      streams[1].push_back(rec_of('0, '1, '1));
      streams[1].push_back(rec_of(64'd5, 32'd2, 64'd2));
      streams[1].push_back(rec_of(ltmd_pkg::ALL_ONES - 64'd1, '1, '1));
      streams[1].push_back(rec_of(ltmd_pkg::ALL_ONES, 32'd3, 64'd3));
      feed_streams(-1);

      // single stream, no tree levels
      end_phase(5'd1);
      set_idling(1);
      build_streams(0, 0);
      streams[0].push_back(rec_of(64'd1, 32'd1, 64'd1));
      streams[0].push_back(rec_of(64'd1, 32'd1, 64'd1));
      streams[0].push_back(rec_of(64'd2, '0, '1));
      feed_streams(-1);

      phase = 1;
      while (sent < ITEM_GOAL) begin
         case (phase)
            1: ways = 5'd31;
            2: ways = 5'd0;
            3, 4: ways = 5'd16;
            default: begin
               pick = $urandom_range(9);
               if (pick < 5) ways = 5'($urandom_range(1, 4));
               else if (pick < 8) ways = 5'($urandom_range(5, 15));
               else ways = 5'($urandom_range(31));
            end
         endcase
         end_phase(ways);
         set_idling(phase);
         p = ledger.lanes();
         if (phase == 4) begin
            set_idling(0);
            hold_asks++;
         end
         if (phase % 5 == 2) begin
            build_streams(0, 0);
            feed_noise($urandom_range(10, 40));
         end else begin
            build_streams(p, (p <= 4) ? 12 : 6);
            feed_streams((phase == 5) ? 10 : -1);
         end
         phase++;
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.expected_words.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.expected_words.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
